// ----- design/iirtdf2_pkg.sv -----
// Shared widths, register indexes, configuration record and datapath operations.
`default_nettype none

package iirtdf2_pkg;

    localparam int ORDER_DEFAULT = 2;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int COEF_W     = 18;
    localparam int STATE_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Fraction alignment: gain path drops 24 bits, output rounding drops 14
    localparam int GAIN_SHIFT = 24;
    localparam int OUT_SHIFT  = 14;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B0_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B1_COEFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B2_COEFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A1_COEFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A2_COEFF   = 3'd5;

    localparam logic [GAIN_W-1:0]        GAIN_RESET = 24'hFF_FFFF;
    localparam logic signed [COEF_W-1:0] B0_RESET   = 18'sd16384;

    typedef struct packed {
        logic [GAIN_W-1:0]        input_gain;
        logic signed [COEF_W-1:0] b0_coeff;
        logic signed [COEF_W-1:0] b1_coeff;
        logic signed [COEF_W-1:0] b2_coeff;
        logic signed [COEF_W-1:0] a1_coeff;
        logic signed [COEF_W-1:0] a2_coeff;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GLO,
        OP_GHI,
        OP_GACC,
        OP_D0ADD,
        OP_ROUND,
        OP_A1,
        OP_A2,
        OP_WB
    } dp_op_t;

endpackage

`default_nettype wire

// ----- design/iirtdf2_sample_in_if.sv -----
// Input sample channel.
`default_nettype none

interface iirtdf2_sample_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [iirtdf2_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ----- design/iirtdf2_sample_out_if.sv -----
// Filtered sample channel.
`default_nettype none

interface iirtdf2_sample_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [iirtdf2_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- design/iirtdf2_cfg_if.sv -----
// Configuration write channel.
`default_nettype none

interface iirtdf2_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [iirtdf2_pkg::CFG_IDX_W-1:0]   index;
    logic [iirtdf2_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/iirtdf2_cfg.sv -----
// Configuration register file for gain and filter coefficients.
`default_nettype none

module iirtdf2_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    iirtdf2_cfg_if.sink        cfg,
    output iirtdf2_pkg::cfg_t  regs
);
    import iirtdf2_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_INPUT_GAIN: regs_next.input_gain = cfg.data;
                REG_B0_COEFF:   regs_next.b0_coeff   = cfg.data[COEF_W-1:0];
                REG_B1_COEFF:   regs_next.b1_coeff   = cfg.data[COEF_W-1:0];
                REG_B2_COEFF:   regs_next.b2_coeff   = cfg.data[COEF_W-1:0];
                REG_A1_COEFF:   regs_next.a1_coeff   = cfg.data[COEF_W-1:0];
                REG_A2_COEFF:   regs_next.a2_coeff   = cfg.data[COEF_W-1:0];
                default:        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.input_gain <= GAIN_RESET;
            regs_reg.b0_coeff   <= B0_RESET;
            regs_reg.b1_coeff   <= '0;
            regs_reg.b2_coeff   <= '0;
            regs_reg.a1_coeff   <= '0;
            regs_reg.a2_coeff   <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/iirtdf2_ctrl.sv -----
// Sequencer: walks one sample through the shared multiplier and drives the handshakes.
`default_nettype none

module iirtdf2_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output iirtdf2_pkg::dp_op_t  op
);
    import iirtdf2_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GLO,
        ST_GHI,
        ST_GACC,
        ST_D0ADD,
        ST_ROUND,
        ST_A1,
        ST_A2,
        ST_WB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_GLO;
                end
            end
            ST_GLO:
            begin
                op         = OP_GLO;
                state_next = ST_GHI;
            end
            ST_GHI:
            begin
                op         = OP_GHI;
                state_next = ST_GACC;
            end
            ST_GACC:
            begin
                op         = OP_GACC;
                state_next = ST_D0ADD;
            end
            ST_D0ADD:
            begin
                op         = OP_D0ADD;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                op         = OP_ROUND;
                state_next = ST_A1;
            end
            ST_A1:
            begin
                op         = OP_A1;
                state_next = ST_A2;
            end
            ST_A2:
            begin
                op         = OP_A2;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_WB;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/iirtdf2_dp.sv -----
// Datapath: shared 25x18 multiplier, accumulators, delay registers and output register.
`default_nettype none

module iirtdf2_dp #(
    parameter int ORDER = iirtdf2_pkg::ORDER_DEFAULT
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire iirtdf2_pkg::dp_op_t                      op,
    input  wire iirtdf2_pkg::cfg_t                        regs,
    input  wire logic signed [iirtdf2_pkg::SAMPLE_W-1:0]  sample_in,
    output logic signed [iirtdf2_pkg::SAMPLE_W-1:0]       sample_out
);
    import iirtdf2_pkg::*;

    localparam int MUL_A_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + COEF_W;
    localparam int XB_W    = SAMPLE_W + COEF_W;
    localparam int SPLIT   = XB_W / 2;
    localparam int ACC_W   = SAMPLE_W + GAIN_W + COEF_W;
    localparam int SUM_W   = STATE_W + 1;
    localparam bit HAS_TOP = (ORDER > 1);

    localparam logic signed [SUM_W-1:0]   RND_HALF = SUM_W'(2 ** (OUT_SHIFT - 1));
    localparam logic signed [SUM_W-1:0]   Y_HI     = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]   Y_LO     = ~Y_HI;
    localparam logic signed [STATE_W-1:0] D_HI     = {1'b0, {(STATE_W - 1){1'b1}}};
    localparam logic signed [STATE_W-1:0] D_LO     = {1'b1, {(STATE_W - 1){1'b0}}};

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v[SUM_W-1] != v[SUM_W-2])
        begin
            r = v[SUM_W-1] ? D_LO : D_HI;
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > Y_HI)
        begin
            r = Y_HI[SAMPLE_W-1:0];
        end
        else if (v < Y_LO)
        begin
            r = Y_LO[SAMPLE_W-1:0];
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    logic signed [SAMPLE_W-1:0]   x_reg;
    logic signed [SAMPLE_W-1:0]   y_reg;
    logic signed [SAMPLE_W-1:0]   out_reg;
    logic signed [XB_W-SPLIT-1:0] phi_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      t0_reg;
    logic signed [SUM_W-1:0]      t1_reg;
    logic signed [STATE_W-1:0]    d_reg [ORDER];

    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [COEF_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [MUL_A_W-1:0]    gain_op;
    logic signed [STATE_W-1:0]    above;
    logic signed [SUM_W-1:0]      rounded;

    assign gain_op    = signed'({1'b0, regs.input_gain});
    assign above      = HAS_TOP ? d_reg[ORDER-1] : '0;
    assign rounded    = (sum_reg + RND_HALF) >>> OUT_SHIFT;
    assign sample_out = out_reg;

    always_comb
    begin
        case (op)
            OP_LOAD:
            begin
                mul_a = MUL_A_W'(sample_in);
                mul_b = regs.b0_coeff;
            end
            OP_GLO:
            begin
                // low half of b0*x, taken as unsigned
                mul_a = gain_op;
                mul_b = COEF_W'(signed'({1'b0, prod_reg[SPLIT-1:0]}));
            end
            OP_GHI:
            begin
                mul_a = gain_op;
                mul_b = COEF_W'(phi_reg);
            end
            OP_GACC:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = regs.b1_coeff;
            end
            OP_D0ADD:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = regs.b2_coeff;
            end
            OP_A1:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = regs.a1_coeff;
            end
            OP_A2:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = regs.a2_coeff;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        // hold the last product while the write-back waits
        if (op != OP_NONE)
        begin
            prod_reg <= prod_next;
        end
        case (op)
            OP_LOAD:
            begin
                x_reg <= sample_in;
            end
            OP_GLO:
            begin
                phi_reg <= prod_reg[XB_W-1:SPLIT];
            end
            OP_GHI:
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            OP_GACC:
            begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SPLIT);
            end
            OP_D0ADD:
            begin
                sum_reg <= SUM_W'(acc_reg >>> GAIN_SHIFT) + SUM_W'(d_reg[0]);
                t0_reg  <= SUM_W'(prod_reg) + SUM_W'(above);
            end
            OP_ROUND:
            begin
                y_reg  <= sat_sample(rounded);
                t1_reg <= SUM_W'(prod_reg);
            end
            OP_A2:
            begin
                t0_reg <= t0_reg - SUM_W'(prod_reg);
            end
            OP_WB:
            begin
                out_reg <= y_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                d_reg[i] <= '0;
            end
        end
        else if (op == OP_WB)
        begin
            d_reg[0] <= sat_state(t0_reg);
            if (HAS_TOP)
            begin
                d_reg[ORDER-1] <= sat_state(t1_reg - SUM_W'(prod_reg));
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/iir_transposed_df2_filter_top.sv -----
// Top level of the second-order transposed direct form II IIR filter section.
`default_nettype none

// Biquad in transposed direct form II on signed Q1.15 samples with Q4.14
// coefficients, a Q0.24 gain on the b0 path and 48-bit delay registers.
// A single 25x18 multiplier is shared over the seven products of a sample,
// which passes through the load, gain low, gain high, accumulate, d0 add,
// round, a1, a2 and write-back steps before its result is presented; the
// next sample is accepted only after that write-back. A finished result
// waits in an output register and does not stop the next sample from being
// accepted; only the write-back of the following result waits for it.
// Configuration writes are taken at any time, in one cycle, and must only be
// issued while no sample is in flight. ORDER 1 keeps a single delay register.
module iir_transposed_df2_filter_top #(
    parameter int ORDER = iirtdf2_pkg::ORDER_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    iirtdf2_sample_in_if.sink      samples,
    iirtdf2_sample_out_if.source   filtered,
    iirtdf2_cfg_if.sink            cfg
);
    import iirtdf2_pkg::*;

    cfg_t   regs;
    dp_op_t op;

    iirtdf2_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    iirtdf2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (filtered.valid),
        .out_ready (filtered.ready),
        .op        (op)
    );

    iirtdf2_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .regs       (regs),
        .sample_in  (samples.sample_in),
        .sample_out (filtered.sample_out)
    );

    // A request is taken only as the first step of a new sample.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |-> (op == OP_LOAD))
        else $error("sample accepted outside the load step");

    // Write-back never overwrites a result still waiting downstream.
    a_wb_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_WB) |-> (!filtered.valid || filtered.ready))
        else $error("write-back over a pending result");

    // A result appears only right after a write-back.
    a_valid_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filtered.valid) |-> ($past(op) == OP_WB))
        else $error("output valid without write-back");

    // Write-back is always followed by a presented result.
    a_wb_presents: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_WB) |=> filtered.valid)
        else $error("write-back did not present a result");

endmodule

`default_nettype wire
